// ===== hdl/transport_checksum_pseudo_header_core_macros.svh =====
// Assertion macros shared by the checksum core.
`ifndef TRANSPORT_CHECKSUM_PSEUDO_HEADER_CORE_MACROS_SVH
`define TRANSPORT_CHECKSUM_PSEUDO_HEADER_CORE_MACROS_SVH

// Clocked check, disabled while reset is held.
`define TCPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TCPH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/tcph_pkg.sv =====
// Widths, constants and types for the transport checksum core.
package tcph_pkg;

    localparam int WORD_W  = 16;
    localparam int PROTO_W = 8;

    localparam logic [WORD_W-1:0]  ONES_MAX    = 16'hFFFF;
    localparam logic [WORD_W-1:0]  TAIL_MASK   = 16'hFF00;
    localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;

    // Input stage contents: word (masked when single byte), first and last flags and the folded pseudo header seed.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first;
        logic [WORD_W-1:0] seed;
        logic              last;
    } t_stage;

endpackage

// ===== hdl/tcph_if.sv =====
// Valid/ready channels for packet words in and checksums out.
interface tcph_in_if
    import tcph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              first_word;
    logic [WORD_W-1:0] segment_length;
    logic              single_byte;
    logic              last_word;

    modport source (
        output valid, data_word, first_word, segment_length, single_byte, last_word,
        input  ready
    );
    modport sink (
        input  valid, data_word, first_word, segment_length, single_byte, last_word,
        output ready
    );
endinterface

interface tcph_out_if
    import tcph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] checksum;

    modport source (
        output valid, checksum,
        input  ready
    );
    modport sink (
        input  valid, checksum,
        output ready
    );
endinterface

// ===== hdl/transport_checksum_pseudo_header_core.sv =====
// A last word's checksum is registered in the output register from the input stage once the output side is free.
// Throughput: one word per cycle; a word stalls only when a finished checksum is still
// waiting in the output register and the word in the input stage is itself a last word.
// Reset (synchronous, active low) clears both stage valids and the running sum to zero
// and sets the protocol number to 6.
`include "transport_checksum_pseudo_header_core_macros.svh"

module transport_checksum_pseudo_header_core
    import tcph_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PROTO_W-1:0] i_cfg_wdata,
    tcph_in_if.sink            i_word_ch,
    tcph_out_if.source         o_sum_ch
);

    logic [PROTO_W-1:0] r_proto;
    t_stage             r_s1;
    logic               r_s1_valid;
    logic [WORD_W-1:0]  r_sum;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_checksum;

    logic [WORD_W:0]    w_seed_raw;
    t_stage             n_s1;
    logic               w_out_free;
    logic               w_consume;
    logic               w_accept;
    logic [WORD_W-1:0]  w_acc;
    logic [WORD_W:0]    w_sum_raw;
    logic [WORD_W-1:0]  n_sum;
    logic [WORD_W-1:0]  n_checksum;

    // Fold protocol plus length at the input so stage two does one add.
    always_comb begin
        w_seed_raw = {1'b0, {(WORD_W-PROTO_W){1'b0}}, r_proto}
                   + {1'b0, i_word_ch.segment_length};
        n_s1.word  = i_word_ch.single_byte ? (i_word_ch.data_word & TAIL_MASK)
                                           : i_word_ch.data_word;
        n_s1.first = i_word_ch.first_word;
        n_s1.last  = i_word_ch.last_word;
        if (w_seed_raw > {1'b0, ONES_MAX}) begin
            n_s1.seed = WORD_W'(w_seed_raw - {1'b0, ONES_MAX});
        end else begin
            n_s1.seed = w_seed_raw[WORD_W-1:0];
        end
    end

    // Words without a result never wait on the output side.
    assign w_out_free = !r_out_valid || o_sum_ch.ready;
    assign w_consume  = r_s1_valid && (!r_s1.last || w_out_free);
    assign w_accept   = i_word_ch.valid && i_word_ch.ready;

    assign i_word_ch.ready = !r_s1_valid || w_consume;

    always_comb begin
        w_acc     = r_s1.first ? r_s1.seed : r_sum;
        w_sum_raw = {1'b0, w_acc} + {1'b0, r_s1.word};
        if (w_sum_raw > {1'b0, ONES_MAX}) begin
            n_sum = WORD_W'(w_sum_raw - {1'b0, ONES_MAX});
        end else begin
            n_sum = w_sum_raw[WORD_W-1:0];
        end
        // Complement of 0xFFFF is zero, which goes out as 0xFFFF.
        n_checksum = (n_sum == ONES_MAX) ? ONES_MAX : ~n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto     <= PROTO_RESET;
            r_s1_valid  <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_proto <= i_cfg_wdata;
            end
            if (i_word_ch.ready) begin
                r_s1_valid <= i_word_ch.valid;
            end
            if (w_consume) begin
                r_sum <= n_sum;
            end
            if (w_consume && r_s1.last) begin
                r_out_valid <= 1'b1;
            end else if (o_sum_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_consume && r_s1.last) begin
            r_out_checksum <= n_checksum;
        end
    end

    assign o_sum_ch.valid    = r_out_valid;
    assign o_sum_ch.checksum = r_out_checksum;

    `TCPH_ASSERT(a_sum_hold, !w_consume |=> $stable(r_sum), "running sum moved with no word")
    `TCPH_ASSERT(a_out_source, $rose(r_out_valid) |-> $past(r_s1_valid && r_s1.last), "result without last word")
    `TCPH_ASSERT(a_no_zero, r_out_valid |-> (r_out_checksum != '0), "zero checksum emitted")
    `TCPH_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> (!r_out_valid && !r_s1_valid && (r_sum == '0)), "reset left state")

endmodule
